@@ design/lu8_pkg.sv @@
// shared types and codes for the line utf-8 prevalidator
// no dependencies; used by lu8_utf8_step and line_utf8_prevalidator_unit
package lu8_pkg;

    // result codes
    typedef enum logic [2:0] {
        VERDICT_PASS     = 3'd0,
        VERDICT_EMPTY    = 3'd1,
        VERDICT_TOO_LONG = 3'd2,
        VERDICT_HAS_NUL  = 3'd3,
        VERDICT_BAD_UTF8 = 3'd4
    } verdict_t;

    // allowed range of the byte after a lead byte
    typedef enum logic [2:0] {
        RULE_NONE  = 3'd0,   // 80..bf
        RULE_A0_BF = 3'd1,   // after e0
        RULE_80_9F = 3'd2,   // after ed
        RULE_90_BF = 3'd3,   // after f0
        RULE_80_8F = 3'd4    // after f4
    } rule_t;

    typedef struct packed {
        logic [1:0] cont_left;
        rule_t      rule;
    } dec_state_t;

    localparam int unsigned LEN_W          = 16;
    localparam logic [LEN_W-1:0] LEN_MAX   = 16'hFFFF;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

    localparam logic [7:0] B_ASCII_MAX = 8'h7F;
    localparam logic [7:0] B_CONT_MIN  = 8'h80;
    localparam logic [7:0] B_CONT_MAX  = 8'hBF;
    localparam logic [7:0] B_2LEAD_MIN = 8'hC2;
    localparam logic [7:0] B_2LEAD_MAX = 8'hDF;
    localparam logic [7:0] B_3LEAD_MIN = 8'hE0;
    localparam logic [7:0] B_3LEAD_MAX = 8'hEF;
    localparam logic [7:0] B_SURR_LEAD = 8'hED;
    localparam logic [7:0] B_4LEAD_MIN = 8'hF0;
    localparam logic [7:0] B_4LEAD_MAX = 8'hF4;
    localparam logic [7:0] B_A0        = 8'hA0;
    localparam logic [7:0] B_9F        = 8'h9F;
    localparam logic [7:0] B_90        = 8'h90;
    localparam logic [7:0] B_8F        = 8'h8F;

endpackage

@@ design/lu8_utf8_step.sv @@
// one byte step of the strict utf-8 decoder (no overlongs, surrogates or > u+10ffff)
// depends on lu8_pkg
module lu8_utf8_step (
    input  logic [7:0]          data_byte,
    input  lu8_pkg::dec_state_t state_cur,
    output lu8_pkg::dec_state_t state_nxt,
    output logic                byte_bad
);
    import lu8_pkg::*;

    logic cont_ok;

    always_comb begin
        case (state_cur.rule)
            RULE_A0_BF: cont_ok = (data_byte >= B_A0) && (data_byte <= B_CONT_MAX);
            RULE_80_9F: cont_ok = (data_byte >= B_CONT_MIN) && (data_byte <= B_9F);
            RULE_90_BF: cont_ok = (data_byte >= B_90) && (data_byte <= B_CONT_MAX);
            RULE_80_8F: cont_ok = (data_byte >= B_CONT_MIN) && (data_byte <= B_8F);
            default:    cont_ok = (data_byte >= B_CONT_MIN) && (data_byte <= B_CONT_MAX);
        endcase
    end

    always_comb begin
        state_nxt = state_cur;
        byte_bad  = 1'b0;
        if (state_cur.cont_left != 2'd0) begin
            state_nxt.rule = RULE_NONE;
            if (cont_ok) begin
                state_nxt.cont_left = state_cur.cont_left - 2'd1;
            end else begin
                state_nxt.cont_left = 2'd0;
                byte_bad            = 1'b1;
            end
        end else if (data_byte <= B_ASCII_MAX) begin
            state_nxt = state_cur;
        end else if ((data_byte >= B_2LEAD_MIN) && (data_byte <= B_2LEAD_MAX)) begin
            state_nxt.cont_left = 2'd1;
            state_nxt.rule      = RULE_NONE;
        end else if ((data_byte >= B_3LEAD_MIN) && (data_byte <= B_3LEAD_MAX)) begin
            state_nxt.cont_left = 2'd2;
            state_nxt.rule      = (data_byte == B_3LEAD_MIN)  ? RULE_A0_BF :
                                  (data_byte == B_SURR_LEAD) ? RULE_80_9F : RULE_NONE;
        end else if ((data_byte >= B_4LEAD_MIN) && (data_byte <= B_4LEAD_MAX)) begin
            state_nxt.cont_left = 2'd3;
            state_nxt.rule      = (data_byte == B_4LEAD_MIN) ? RULE_90_BF :
                                  (data_byte == B_4LEAD_MAX) ? RULE_80_8F : RULE_NONE;
        end else begin
            // stray continuation or forbidden lead byte
            byte_bad = 1'b1;
        end
    end

endmodule

@@ design/line_utf8_prevalidator_unit.sv @@
// top level of the line utf-8 prevalidator: input register, line state, result register
// depends on lu8_pkg and lu8_utf8_step

// Screens a received text line one byte per item and gives one result item at
// the end of each line. A byte item carries the byte in s_tdata and s_tlast on
// the final byte; an item with s_tuser set ends an empty line (its byte and
// tlast are ignored, and any partly received line is dropped). The result
// carries a verdict (pass, empty, too long, contains nul, invalid utf-8, in
// that precedence: empty first, then too long, nul, encoding) and the byte
// count of the line, which saturates at 65535. The utf-8 check is strict:
// overlong forms, surrogates, code points above u+10ffff, stray continuation
// bytes and a sequence cut short by the end of the line are all invalid.
// Rate: one item per cycle while no line-end item is held back; an item is
// registered on entry in the input register, and when it advances its line
// state update and result are registered, the result into the result
// register that drives m_*. Only a full result register holds back a line-end
// item, and through it the input.
// max_line_length is written on cfg_* (always ready), by the user only while no
// line is in progress (the block does not enforce this); it resets to 1024.
module line_utf8_prevalidator_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    // item input
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] data_byte
    input  logic                      s_tlast,   // last_byte
    input  logic                      s_tuser,   // empty_line
    // result output
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // [2:0] verdict, [18:3] line_length, rest 0
    // configuration: max_line_length
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lu8_pkg::LEN_W-1:0] cfg_data
);
    import lu8_pkg::*;

    // configuration register
    logic [LEN_W-1:0] max_len_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // line state
    logic [LEN_W-1:0] byte_count_reg, byte_count_next;
    dec_state_t       dec_reg, dec_next;
    logic             nul_seen_reg, nul_seen_next;
    logic             bad_reg, bad_next;

    // result register
    logic             out_valid_reg;
    verdict_t         out_verdict_reg, out_verdict_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;

    // step signals
    dec_state_t       dec_step;
    logic             step_bad;
    logic [LEN_W-1:0] count_inc;
    logic             bad_final;
    logic             has_result;
    logic             out_free;
    logic             advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_valid) begin
            max_len_reg <= cfg_data;
        end
    end

    lu8_utf8_step u_step (
        .data_byte (in_byte_reg),
        .state_cur (dec_reg),
        .state_nxt (dec_step),
        .byte_bad  (step_bad)
    );

    // the registered item leaves when it makes no result or the result slot is free
    assign has_result = in_empty_reg || in_last_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign advance    = in_valid_reg && (!has_result || out_free);
    assign s_tready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
    end

    assign count_inc = (byte_count_reg == LEN_MAX) ? LEN_MAX : byte_count_reg + 16'd1;
    // a sequence still open at the line end counts as an error
    assign bad_final = bad_reg || step_bad || (dec_step.cont_left != 2'd0);

    always_comb begin
        byte_count_next  = byte_count_reg;
        dec_next         = dec_reg;
        nul_seen_next    = nul_seen_reg;
        bad_next         = bad_reg;
        out_verdict_next = out_verdict_reg;
        out_len_next     = out_len_reg;
        if (advance) begin
            if (in_empty_reg) begin
                byte_count_next  = '0;
                dec_next         = '{cont_left: 2'd0, rule: RULE_NONE};
                nul_seen_next    = 1'b0;
                bad_next         = 1'b0;
                out_verdict_next = VERDICT_EMPTY;
                out_len_next     = '0;
            end else if (in_last_reg) begin
                if (count_inc > max_len_reg) begin
                    out_verdict_next = VERDICT_TOO_LONG;
                end else if (nul_seen_reg || (in_byte_reg == 8'h00)) begin
                    out_verdict_next = VERDICT_HAS_NUL;
                end else if (bad_final) begin
                    out_verdict_next = VERDICT_BAD_UTF8;
                end else begin
                    out_verdict_next = VERDICT_PASS;
                end
                out_len_next    = count_inc;
                byte_count_next = '0;
                dec_next        = '{cont_left: 2'd0, rule: RULE_NONE};
                nul_seen_next   = 1'b0;
                bad_next        = 1'b0;
            end else begin
                byte_count_next = count_inc;
                dec_next        = dec_step;
                nul_seen_next   = nul_seen_reg || (in_byte_reg == 8'h00);
                bad_next        = bad_reg || step_bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            dec_reg        <= '{cont_left: 2'd0, rule: RULE_NONE};
            nul_seen_reg   <= 1'b0;
            bad_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            dec_reg        <= dec_next;
            nul_seen_reg   <= nul_seen_next;
            bad_reg        <= bad_next;
            if (advance && has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_verdict_reg <= out_verdict_next;
        out_len_reg     <= out_len_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_len_reg, out_verdict_reg};

`ifndef SYNTHESIS
    // a second-byte rule only exists right after a three or four byte lead
    a_rule_needs_open_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_reg.rule != RULE_NONE) |-> (dec_reg.cont_left == 2'd2 || dec_reg.cont_left == 2'd3))
        else $error("second-byte rule set without open multi-byte sequence");

    // an empty-line result always reports zero length
    a_empty_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_verdict_reg == VERDICT_EMPTY) |-> (out_len_reg == '0))
        else $error("empty verdict with nonzero length");

    // a passing line is never empty and never over the limit
    a_pass_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_verdict_reg == VERDICT_PASS)
            |-> (out_len_reg != '0 && out_len_reg <= max_len_reg))
        else $error("pass verdict on a line outside the length limit");

    // input only stalls behind a held line-end item
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && has_result && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // a result that is taken while a line end advances is replaced, not lost
    a_result_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && has_result) |=> out_valid_reg)
        else $error("line-end item left without producing a result");
`endif

endmodule
